### design/life_generation_row_step_assert.svh
// Assertion macros for the checker file of this block.
`ifndef LIFE_GENERATION_ROW_STEP_ASSERT_SVH
`define LIFE_GENERATION_ROW_STEP_ASSERT_SVH

// Clocked property, held off while reset is asserted
`define LGRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold whenever a result item is shown
`define LGRS_ASSERT_OUT(lbl, prop, msg) \
  `LGRS_ASSERT(lbl, out_valid_i |-> (prop), msg)

`endif

### design/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Types and constants shared by the Life row-step block.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int unsigned RowW   = 64;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned WidthW = 7;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // Neighbor counts of the B3/S23 rule
  localparam logic [3:0] NbrBorn = 4'd3;
  localparam logic [3:0] NbrKeep = 4'd2;

  // Register map, word index
  localparam logic RegGridWidth = 1'b0;

  // Reset value of the grid width register
  localparam logic [WidthW-1:0] GridWidthRst = 7'd64;

  // Result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic [RowW-1:0] row_cells;
    logic            last_row;
  } lgrs_in_t;

  typedef struct packed {
    logic [RowW-1:0] next_cells;
    logic [IdxW-1:0] out_row;
    logic            grid_done;
  } lgrs_out_t;

  // Up to two results pushed into the queue in one cycle
  typedef struct packed {
    logic      v0;
    lgrs_out_t d0;
    logic      v1;
    lgrs_out_t d1;
  } lgrs_push_t;

  // Count the live cells among eight neighbors
  function automatic logic [3:0] popcount8(logic [7:0] bits);
    logic [3:0] sum;
    sum = 4'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, bits[i]};
    end
    return sum;
  endfunction

endpackage

### design/life_generation_row_step.sv
// ----------------------------------------------------------------------------
// life_generation_row_step
// One Conway Life generation (B3/S23), streamed one grid row per item.
// ----------------------------------------------------------------------------
// Rows enter top to bottom on the in channel (valid/ready); row r (r >= 1)
// gives output row r-1, and a row marked last, or row MAX_ROWS-1, also gives
// its own dead row with grid_done set. Row 0 alone gives nothing unless last.
// An accepted row waits in the input stage register until the result queue
// has room for its results, which are then pushed into that queue, whose
// output drives out_data_o; a second result follows the first. Throughput:
// one row per cycle while the receiver takes results and each row yields one
// result. A grid's closing row yields two, which share the queue's one output.
// Border rows, border columns and columns at or beyond grid_width are dead.
// The grid width register sits at byte address 0 of the APB port and resets
// to 64; reset also clears the kept rows and the row counter.
// When the receiver stalls, results wait in a four-entry queue and input
// stays open while the queue has room for the staged item's results.
// ----------------------------------------------------------------------------
module life_generation_row_step
  import lgrs_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lgrs_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lgrs_out_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam logic [IdxW-1:0]   LastIdx = IdxW'(MAX_ROWS - 1);
  localparam logic [WidthW-1:0] ColMax  = WidthW'(MAX_COLUMNS);

  logic [WidthW-1:0] grid_width_q;
  logic [RowW-1:0]   row_above_q, row_middle_q;
  logic [IdxW-1:0]   rows_seen_q;

  logic              s_valid_q, s_valid_d;
  logic [RowW-1:0]   s_up_q, s_mid_q, s_down_q;
  logic [IdxW-1:0]   s_row_q;
  logic              s_last_q;

  logic              in_fire, in_last, s_fire;
  logic              s_has_prev, s_has_two;
  logic [1:0]        s_cnt;
  logic [QCntW-1:0]  q_free;
  logic [WidthW-1:0] eff_width;
  logic [RowW-1:0]   life_cells;
  lgrs_push_t        push;
  logic              reg_write, reg_sel;

  // Configuration port
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[AddrW-1] == RegGridWidth);
  assign reg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? {{(DataW-WidthW){1'b0}}, grid_width_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= GridWidthRst;
    end else if (reg_write) begin
      grid_width_q <= pwdata[WidthW-1:0];
    end
  end

  // Input handshake and end-of-grid detection
  assign in_ready_o = !s_valid_q || s_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_last    = in_data_i.last_row || (rows_seen_q >= LastIdx);

  // Row window: keep the two previous rows, restart after the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_above_q  <= '0;
      row_middle_q <= '0;
      rows_seen_q  <= '0;
    end else if (in_fire) begin
      if (in_last) begin
        row_above_q  <= '0;
        row_middle_q <= '0;
        rows_seen_q  <= '0;
      end else begin
        row_above_q  <= row_middle_q;
        row_middle_q <= in_data_i.row_cells;
        rows_seen_q  <= rows_seen_q + IdxW'(1);
      end
    end
  end

  // Input stage register
  always_comb begin
    s_valid_d = s_valid_q;
    if (in_fire) begin
      s_valid_d = 1'b1;
    end else if (s_fire) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_up_q   <= row_above_q;
      s_mid_q  <= row_middle_q;
      s_down_q <= in_data_i.row_cells;
      s_row_q  <= rows_seen_q;
      s_last_q <= in_last;
    end
  end

  // Results of the staged item, released when the queue has room
  assign s_has_prev = (s_row_q != '0);
  assign s_has_two  = (s_row_q >= IdxW'(2));
  assign s_cnt      = {1'b0, s_has_prev} + {1'b0, s_last_q};
  assign s_fire     = s_valid_q && ({{(QCntW-2){1'b0}}, s_cnt} <= q_free);
  assign eff_width  = (grid_width_q > ColMax) ? ColMax : grid_width_q;

  lgrs_cell_row u_cell_row (
    .up_i    (s_up_q),
    .mid_i   (s_mid_q),
    .down_i  (s_down_q),
    .width_i (eff_width),
    .next_o  (life_cells)
  );

  always_comb begin
    push.v0            = s_fire && s_has_prev;
    push.d0.next_cells = s_has_two ? life_cells : '0;
    push.d0.out_row    = s_row_q - IdxW'(1);
    push.d0.grid_done  = 1'b0;
    push.v1            = s_fire && s_last_q;
    push.d1.next_cells = '0;
    push.d1.out_row    = s_row_q;
    push.d1.grid_done  = 1'b1;
  end

  lgrs_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (q_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/lgrs_cell_row.sv
// ----------------------------------------------------------------------------
// lgrs_cell_row
// Next generation of one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module lgrs_cell_row
  import lgrs_pkg::*;
(
  input  logic [RowW-1:0]   up_i,
  input  logic [RowW-1:0]   mid_i,
  input  logic [RowW-1:0]   down_i,
  input  logic [WidthW-1:0] width_i,
  output logic [RowW-1:0]   next_o
);

  // Border columns are always dead
  assign next_o[0]      = 1'b0;
  assign next_o[RowW-1] = 1'b0;

  // Interior columns: neighbors of column c lie within 0..width-1
  for (genvar c = 1; c < RowW - 1; c++) begin : g_col
    logic [3:0] nbr;
    logic       interior;

    assign nbr = popcount8({up_i[c-1], up_i[c], up_i[c+1],
                            mid_i[c-1], mid_i[c+1],
                            down_i[c-1], down_i[c], down_i[c+1]});
    assign interior = (WidthW'(c + 1) < width_i);
    assign next_o[c] = interior && ((nbr == NbrBorn) || (mid_i[c] && (nbr == NbrKeep)));
  end

endmodule

### design/lgrs_result_queue.sv
// ----------------------------------------------------------------------------
// lgrs_result_queue
// Small result queue, takes up to two items per cycle and hands out one while the receiver is ready.
// ----------------------------------------------------------------------------
module lgrs_result_queue
  import lgrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lgrs_push_t       push_i,
  output logic [QCntW-1:0] free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lgrs_out_t        out_data_o
);

  lgrs_out_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic [QPtrW-1:0] wr_ptr1;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];

  // Free slots, counting the item leaving this cycle
  assign free_o = QCntW'(QDepth) - count_q + {{(QCntW-1){1'b0}}, pop};

  // Second item goes behind the first, or to the first free slot alone
  assign wr_ptr1 = wr_ptr_q + {{(QPtrW-1){1'b0}}, push_i.v0};

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + {{(QPtrW-1){1'b0}}, push_i.v0}
                        + {{(QPtrW-1){1'b0}}, push_i.v1};
    rd_ptr_d = rd_ptr_q + {{(QPtrW-1){1'b0}}, pop};
    count_d  = count_q + {{(QCntW-1){1'b0}}, push_i.v0}
                       + {{(QCntW-1){1'b0}}, push_i.v1}
                       - {{(QCntW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.d0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr1] <= push_i.d1;
    end
  end

endmodule

### design/lgrs_checker.sv
// ----------------------------------------------------------------------------
// lgrs_checker
// Port-level checks of the Life row-step block, bound to its top level.
// ----------------------------------------------------------------------------
`include "life_generation_row_step_assert.svh"

module lgrs_checker
  import lgrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  lgrs_out_t out_data_i,
  input  logic      pready_i
);

  // Hold a stalled result item
  `LGRS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "stalled result item changed")

  // Border columns are never alive
  `LGRS_ASSERT_OUT(a_border_dead, !out_data_i.next_cells[0] && !out_data_i.next_cells[RowW-1], "border column alive")

  // Top row and the closing row are dead
  `LGRS_ASSERT_OUT(a_edge_rows_dead, !((out_data_i.out_row == '0) || out_data_i.grid_done) || (out_data_i.next_cells == '0), "top or bottom row alive")

  // Configuration port never waits
  `LGRS_ASSERT(a_pready, pready_i, "pready dropped")

endmodule

bind life_generation_row_step lgrs_checker u_lgrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o),
  .pready_i    (pready)
);
